// ----- design/dsu_pkg.sv -----
// Shared types, constants and helpers for the disjoint-set union-find engine.
package dsu_pkg;

    localparam int TABLE_DEPTH      = 1024;
    localparam int IDX_W            = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W          = IDX_W + 1;
    localparam int ELEM_W           = 10;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;
    localparam int NUM_ELEMS_RESET  = 1023;

    localparam logic REG_NUM_ELEMENTS = 1'b0;
    localparam logic FUNC_UNION       = 1'b0;

    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic [ELEM_W-1:0]         t_elem;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_COMP,
        ST_JOIN,
        ST_LINK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        t_entry wdata;
        t_idx   raddr;
    } t_mem_req;

    typedef struct packed {
        logic  connected;
        t_elem count;
        logic  error;
    } t_result;

    function automatic t_elem limit_elems(input t_elem num);
        if (int'(num) > TABLE_DEPTH - 1) begin
            return ELEM_W'(TABLE_DEPTH - 1);
        end
        return num;
    endfunction

endpackage

// ----- design/dsu_ram.sv -----
// Parent table memory: one write port, one registered read port, write-first.
module dsu_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/dsu_ctrl.sv -----
// Sequencer that walks parent links, compresses paths and joins sets.
module dsu_ctrl import dsu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  logic     i_func,
    input  t_elem    i_elem_a,
    input  t_elem    i_elem_b,
    input  t_elem    i_num_elements,
    input  logic     i_out_free,
    input  t_entry   i_rdata,
    output logic     o_ready,
    output t_mem_req o_mem,
    output logic     o_result_valid,
    output t_result  o_result
);

    t_state r_state, n_state;
    logic   r_phase_b, n_phase_b;
    t_elem  r_merge_count, n_merge_count;
    t_idx   r_clr_addr, n_clr_addr;
    logic   r_func, n_func;
    logic   r_err, n_err;
    t_idx   r_elem_a, n_elem_a;
    t_idx   r_elem_b, n_elem_b;
    t_idx   r_cur, n_cur;
    t_idx   r_root_a, n_root_a;
    t_idx   r_root_b, n_root_b;
    t_entry r_size_a, n_size_a;
    t_entry r_size_b, n_size_b;

    t_elem  lim;
    logic   in_err;
    logic   rd_root;
    t_idx   rd_par;
    t_idx   start;
    logic   start_is_root;
    t_idx   cur_root;
    logic   do_union;
    logic   b_big;

    assign lim    = limit_elems(i_num_elements);
    assign in_err = (i_elem_a == '0) || (i_elem_b == '0) ||
                    (i_elem_a > lim) || (i_elem_b > lim);

    assign rd_root       = i_rdata[ENTRY_W-1];
    assign rd_par        = i_rdata[IDX_W-1:0];
    assign start         = r_phase_b ? r_elem_b : r_elem_a;
    assign start_is_root = (start == r_cur);
    assign cur_root      = r_phase_b ? r_root_b : r_root_a;
    assign do_union      = (r_func == FUNC_UNION) && (r_root_a != r_root_b);
    assign b_big         = r_size_b < r_size_a;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = in_err ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                if (rd_root) begin
                    if (!start_is_root) begin
                        n_state = ST_COMP;
                    end else if (r_phase_b) begin
                        n_state = ST_JOIN;
                    end
                end
            end
            ST_COMP: begin
                if (rd_par == cur_root) begin
                    n_state = r_phase_b ? ST_JOIN : ST_WALK;
                end
            end
            ST_JOIN: begin
                n_state = do_union ? ST_LINK : ST_DONE;
            end
            ST_LINK: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_phase_b     = r_phase_b;
        n_merge_count = r_merge_count;
        n_clr_addr    = r_clr_addr;
        n_func        = r_func;
        n_err         = r_err;
        n_elem_a      = r_elem_a;
        n_elem_b      = r_elem_b;
        n_cur         = r_cur;
        n_root_a      = r_root_a;
        n_root_b      = r_root_b;
        n_size_a      = r_size_a;
        n_size_b      = r_size_b;
        o_mem.we      = 1'b0;
        o_mem.waddr   = r_cur;
        o_mem.wdata   = '0;
        o_mem.raddr   = r_cur;
        case (r_state)
            ST_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr_addr;
                o_mem.wdata = t_entry'(-1);
                n_clr_addr  = r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
                o_mem.raddr = IDX_W'(i_elem_a);
                if (i_accept) begin
                    n_func    = i_func;
                    n_err     = in_err;
                    n_elem_a  = IDX_W'(i_elem_a);
                    n_elem_b  = IDX_W'(i_elem_b);
                    n_cur     = IDX_W'(i_elem_a);
                    n_phase_b = 1'b0;
                end
            end
            ST_WALK: begin
                if (rd_root) begin
                    if (r_phase_b) begin
                        n_root_b = r_cur;
                        n_size_b = i_rdata;
                    end else begin
                        n_root_a = r_cur;
                        n_size_a = i_rdata;
                    end
                    if (!start_is_root) begin
                        n_cur       = start;
                        o_mem.raddr = start;
                    end else if (!r_phase_b) begin
                        n_phase_b   = 1'b1;
                        n_cur       = r_elem_b;
                        o_mem.raddr = r_elem_b;
                    end
                end else begin
                    n_cur       = rd_par;
                    o_mem.raddr = rd_par;
                end
            end
            ST_COMP: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_cur;
                o_mem.wdata = t_entry'({1'b0, cur_root});
                if (rd_par == cur_root) begin
                    if (!r_phase_b) begin
                        n_phase_b   = 1'b1;
                        n_cur       = r_elem_b;
                        o_mem.raddr = r_elem_b;
                    end
                end else begin
                    n_cur       = rd_par;
                    o_mem.raddr = rd_par;
                end
            end
            ST_JOIN: begin
                if (do_union) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = b_big ? r_root_b : r_root_a;
                    o_mem.wdata = r_size_a + r_size_b;
                end
            end
            ST_LINK: begin
                o_mem.we      = 1'b1;
                o_mem.waddr   = b_big ? r_root_a : r_root_b;
                o_mem.wdata   = t_entry'({1'b0, (b_big ? r_root_b : r_root_a)});
                n_merge_count = r_merge_count + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_phase_b     <= 1'b0;
            r_merge_count <= '0;
            r_clr_addr    <= '0;
        end else begin
            r_state       <= n_state;
            r_phase_b     <= n_phase_b;
            r_merge_count <= n_merge_count;
            r_clr_addr    <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_err    <= n_err;
        r_elem_a <= n_elem_a;
        r_elem_b <= n_elem_b;
        r_cur    <= n_cur;
        r_root_a <= n_root_a;
        r_root_b <= n_root_b;
        r_size_a <= n_size_a;
        r_size_b <= n_size_b;
    end

    assign o_ready            = (r_state == ST_IDLE);
    assign o_result_valid     = (r_state == ST_DONE);
    assign o_result.connected = !r_err && (r_root_a == r_root_b);
    assign o_result.count     = (r_merge_count > lim) ? '0 : (lim - r_merge_count);
    assign o_result.error     = r_err;

endmodule

// ----- design/disjoint_set_union_find.sv -----
// Top level of the disjoint-set union-find engine with its register port.
//
// After reset the engine sets every table entry to a singleton set, and
// holds o_in_stall high during that time. It then works on one item at a
// time. An item with an element out of range goes straight to its result.
// For any other item the single read port of the parent table follows
// one parent link per cycle from each element to its root, and path
// compression writes one entry per cycle on a second pass over each path.
// A union of two different sets then writes the summed size to the larger
// root, the first element's on a tie, and links the other root under it.
// Union by size and path compression keep these paths short. The result
// waits in an output register, so the engine may take the next item while
// the previous result is still stalled.
module disjoint_set_union_find import dsu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [ELEM_W-1:0]     i_elem_a,
    input  logic [ELEM_W-1:0]     i_elem_b,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_connected,
    output logic [ELEM_W-1:0]     o_component_count,
    output logic                  o_error
);

    t_elem    r_num_elements;
    logic     r_out_valid;
    t_result  r_out;
    logic     ready;
    logic     accept;
    logic     out_free;
    logic     result_valid;
    t_result  result;
    t_mem_req mem;
    t_entry   rdata;
    logic     cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[APB_ADDR_W-1] == REG_NUM_ELEMENTS);
    assign prdata    = (paddr[APB_ADDR_W-1] == REG_NUM_ELEMENTS) ?
                       APB_DATA_W'(r_num_elements) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_elements <= ELEM_W'(NUM_ELEMS_RESET);
        end else if (cfg_write) begin
            r_num_elements <= pwdata[ELEM_W-1:0];
        end
    end

    assign o_in_stall = !ready;
    assign accept     = i_in_valid && ready;
    assign out_free   = !r_out_valid || !i_out_stall;

    dsu_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    dsu_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_func         (i_func),
        .i_elem_a       (i_elem_a),
        .i_elem_b       (i_elem_b),
        .i_num_elements (r_num_elements),
        .i_out_free     (out_free),
        .i_rdata        (rdata),
        .o_ready        (ready),
        .o_mem          (mem),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= result_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && result_valid) begin
            r_out <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_connected       = r_out.connected;
    assign o_component_count = r_out.count;
    assign o_error           = r_out.error;

    a_error_not_connected: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> !o_connected
    ) else $error("Error result reports a connection.");

    a_one_item_at_a_time: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("Second item accepted while one is in progress.");

    a_count_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_component_count <= r_num_elements)
    ) else $error("Component count exceeds the element count.");

    a_no_write_when_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall) |-> !mem.we
    ) else $error("Parent table written while the engine is idle.");

endmodule

// ----- tb/disjoint_set_union_find_test.sv -----
// Self-checking testbench for the disjoint-set union-find engine.
module disjoint_set_union_find_test import dsu_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FUNC_FIND = !FUNC_UNION;

    typedef struct {
        logic  func;
        t_elem elem_a;
        t_elem elem_b;
    } t_dsu_op;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_func = 1'b0;
    logic [ELEM_W-1:0]     i_elem_a = '0;
    logic [ELEM_W-1:0]     i_elem_b = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_connected;
    logic [ELEM_W-1:0]     o_component_count;
    logic                  o_error;
    logic                  hold_long = 1'b0;

    t_dsu_op     op_queue[$];
    t_result     expected_answers[$];
    t_dsu_op     cur_op;
    int          link_table[TABLE_DEPTH];
    int unsigned joins;
    int unsigned cfg_elems;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned answers_checked = 0;
    int unsigned mismatches = 0;
    bit          sender_calm = 1'b0;
    bit          receiver_calm = 1'b0;

    disjoint_set_union_find dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_func(i_func),
        .i_elem_a(i_elem_a),
        .i_elem_b(i_elem_b),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_connected(o_connected),
        .o_component_count(o_component_count),
        .o_error(o_error)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Finds the root of an element and points every entry on the path at it.
    function automatic int unsigned root_of(input int unsigned elem);
        int unsigned r;
        int unsigned cur;
        int unsigned nxt;
        r = elem;
        while (link_table[r] >= 0) begin
            r = link_table[r];
        end
        cur = elem;
        while (cur != r) begin
            nxt = link_table[cur];
            link_table[cur] = r;
            cur = nxt;
        end
        return r;
    endfunction

    function automatic t_result predict_answer(input t_dsu_op op);
        t_result     res;
        int unsigned lim;
        int unsigned ra;
        int unsigned rb;
        res = '0;
        lim = (cfg_elems > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : cfg_elems;
        if (op.elem_a == 0 || op.elem_b == 0 || op.elem_a > lim || op.elem_b > lim) begin
            res.error = 1'b1;
        end else begin
            ra = root_of(op.elem_a);
            rb = root_of(op.elem_b);
            res.connected = (ra == rb);
            if (op.func == FUNC_UNION && ra != rb) begin
                if (link_table[rb] < link_table[ra]) begin
                    link_table[rb] = link_table[rb] + link_table[ra];
                    link_table[ra] = rb;
                end else begin
                    link_table[ra] = link_table[ra] + link_table[rb];
                    link_table[rb] = ra;
                end
                joins = (joins + 1) % 1024;
            end
        end
        res.count = t_elem'((joins > lim) ? 0 : lim - joins);
        return res;
    endfunction

    function automatic t_elem pick_elem(input int unsigned n);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            return '0;
        end
        if (roll < 10 || n == 0) begin
            return t_elem'($urandom_range(0, TABLE_DEPTH - 1));
        end
        if (roll < 14 && n < TABLE_DEPTH - 1) begin
            return t_elem'($urandom_range(n + 1, TABLE_DEPTH - 1));
        end
        return t_elem'($urandom_range(1, n));
    endfunction

    task automatic push_op(input logic func, input int unsigned a, input int unsigned b);
        t_dsu_op op;
        op.func = func;
        op.elem_a = t_elem'(a);
        op.elem_b = t_elem'(b);
        op_queue.push_back(op);
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (op_queue.size() != 0 || i_in_valid || expected_answers.size() != 0);
    endtask

    task automatic run_phase(input int unsigned n, input int unsigned count);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * int'(REG_NUM_ELEMENTS));
        pwdata <= APB_DATA_W'(n);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_elems = n;
        @(negedge i_clk);
        repeat (count) begin
            push_op(logic'($urandom_range(0, 1)), pick_elem(n), pick_elem(n));
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_answers.push_back(predict_answer(cur_op));
                if ($urandom_range(0, 39) == 0) begin
                    sender_calm = !sender_calm;
                end
                gap_left = sender_calm ? 0 : $urandom_range(0, 10);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    cur_op = op_queue.pop_front();
                    i_func <= cur_op.func;
                    i_elem_a <= cur_op.elem_a;
                    i_elem_b <= cur_op.elem_b;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                answers_checked = answers_checked + 1;
                if (expected_answers.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("unexpected transfer: connected=%0d count=%0d error=%0d",
                                 o_connected, o_component_count, o_error);
                    end
                end else begin
                    want = expected_answers.pop_front();
                    if (o_connected !== want.connected || o_component_count !== want.count
                            || o_error !== want.error) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("transfer %0d: expected connected=%0d count=%0d error=%0d,",
                                     answers_checked, want.connected, want.count,
                                     want.error);
                            $display("    got connected=%0d count=%0d error=%0d",
                                     o_connected, o_component_count, o_error);
                        end
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    receiver_calm = !receiver_calm;
                end
                stall_left = receiver_calm ? 0 : $urandom_range(0, 10);
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
            end
            i_out_stall <= hold_long || (stall_left > 0);
        end
    end

    // The receiver holds off for a long stretch so that the engine backs up.
    initial begin
        while (answers_checked < 500) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        hold_long <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_long <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("disjoint_set_union_find_test failed");
        $finish;
    end

    initial begin
        foreach (link_table[i]) begin
            link_table[i] = -1;
        end
        joins = 0;
        cfg_elems = NUM_ELEMS_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_op(FUNC_FIND, 1, 1);
        push_op(FUNC_UNION, 1, 2);
        push_op(FUNC_UNION, 3, 4);
        push_op(FUNC_UNION, 1, 3);
        push_op(FUNC_UNION, 2, 4);
        push_op(FUNC_FIND, 4, 1);
        push_op(FUNC_UNION, 1023, 1022);
        push_op(FUNC_UNION, 5, 1023);
        push_op(FUNC_FIND, 0, 5);
        push_op(FUNC_UNION, 5, 0);
        push_op(FUNC_UNION, 0, 0);
        push_op(FUNC_FIND, 1023, 1023);
        push_op(FUNC_UNION, 512, 511);
        push_op(FUNC_FIND, 682, 341);
        push_op(FUNC_UNION, 1, 1023);
        push_op(FUNC_FIND, 2, 1022);
        push_op(FUNC_UNION, 4, 5);
        wait_idle();

        run_phase(0, 15);
        run_phase(1, 15);
        run_phase(16, 250);
        run_phase(128, 450);
        run_phase(1023, 750);
        run_phase(600, 300);
        run_phase(1023, 150);

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("disjoint_set_union_find_test passed");
        end else begin
            $display("disjoint_set_union_find_test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/dsu_pkg.sv
design/dsu_ram.sv
design/dsu_ctrl.sv
design/disjoint_set_union_find.sv
tb/disjoint_set_union_find_test.sv
